/* rtl/cbc_pkg.sv */
// cbc_pkg: shared types and constants for the color blob centroid/crosshair block.
// Used by cbc_front, cbc_fifo, cbc_back and color_blob_centroid_crosshair.
// No dependencies.
package cbc_pkg;

    localparam int PIX_W     = 32;
    localparam int COLOR_W   = 8;
    localparam int FRAME_W   = 13;
    localparam int CENT_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int Q_DEPTH   = 4;

    localparam logic [PIX_W-1:0] WHITE = 32'h00ff_ffff;

    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_DRAW    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd7;

    localparam logic [COLOR_W-1:0] RST_RED_LOW      = 8'd0;
    localparam logic [COLOR_W-1:0] RST_RED_HIGH     = 8'd100;
    localparam logic [COLOR_W-1:0] RST_GREEN_LOW    = 8'd0;
    localparam logic [COLOR_W-1:0] RST_GREEN_HIGH   = 8'd100;
    localparam logic [COLOR_W-1:0] RST_BLUE_LOW     = 8'd150;
    localparam logic [COLOR_W-1:0] RST_BLUE_HIGH    = 8'd254;
    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic [COLOR_W-1:0] lo;
        logic [COLOR_W-1:0] hi;
    } cbc_window_t;

    typedef struct packed {
        cbc_window_t red;
        cbc_window_t green;
        cbc_window_t blue;
    } cbc_color_win_t;

    // per-word control bits carried through the queue
    typedef struct packed {
        logic func;
        logic hit;
        logic last;
    } cbc_tag_t;

    localparam int TAG_W = $bits(cbc_tag_t);

endpackage

/* rtl/cbc_front.sv */
// cbc_front: accepts input words, tracks raster position, runs the color window test.
// Pushes {tag, col, row, pixel} into the queue. Depends on cbc_pkg.
module cbc_front
    import cbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = 12,
    parameter int RW         = 12,
    parameter int DW         = TAG_W + CW + RW + PIX_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                func,
    input  logic [PIX_W-1:0]    pixel_in,
    input  cbc_color_win_t      win,
    input  logic [FRAME_W-1:0]  frame_width,
    input  logic [FRAME_W-1:0]  frame_height,
    input  logic                q_full,
    output logic                q_push,
    output logic [DW-1:0]       q_word
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic          row_end;
    logic          last;
    logic          hit;
    cbc_tag_t      tag;

    function automatic logic in_window(input logic [COLOR_W-1:0] v, input cbc_window_t w);
        in_window = (v > w.lo) && (v < w.hi);
    endfunction

    // effective size minus one: zero counts as one, oversize clips to the maximum
    always_comb
    begin
        if (frame_width == '0)
            wm1 = '0;
        else if (32'(frame_width) > 32'(MAX_WIDTH))
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(frame_width - FRAME_W'(1));

        if (frame_height == '0)
            hm1 = '0;
        else if (32'(frame_height) > 32'(MAX_HEIGHT))
            hm1 = RW'(MAX_HEIGHT - 1);
        else
            hm1 = RW'(frame_height - FRAME_W'(1));
    end

    assign row_end = (col_reg >= wm1);
    assign last    = row_end && (row_reg >= hm1);
    assign hit     = in_window(pixel_in[7:0], win.red) &&
                     in_window(pixel_in[15:8], win.green) &&
                     in_window(pixel_in[23:16], win.blue);

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    assign tag.func = func;
    assign tag.hit  = hit;
    assign tag.last = last;
    assign q_word   = {tag, col_reg, row_reg, pixel_in};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/cbc_fifo.sv */
// cbc_fifo: short show-ahead queue between the front and back parts.
// Generic data width; depth is a power of two. Takes its default depth from cbc_pkg.
module cbc_fifo
    import cbc_pkg::*;
#(
    parameter int DW    = 32,
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_word,
    input  logic          pop,
    output logic [DW-1:0] pop_word,
    output logic          not_empty,
    output logic          full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign pop_word  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + (AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + (AW+1)'(1))
        else $error("queue count lost a push");

endmodule

/* rtl/cbc_back.sv */
// cbc_back: pops classified words, accumulates hit sums, divides to the centroid
// at frame end (one quotient bit per cycle), draws the crosshair. Depends on cbc_pkg.
module cbc_back
    import cbc_pkg::*;
#(
    parameter int HALF_BAND = 10,
    parameter int CW        = 12,
    parameter int RW        = 12,
    parameter int DW        = TAG_W + CW + RW + PIX_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [DW-1:0]     q_word,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              pass_done,
    output logic [CENT_W-1:0] centroid_col,
    output logic [CENT_W-1:0] centroid_row
);

    localparam int QW  = (CW > RW) ? CW : RW;
    localparam int SW  = CW + RW + QW + 1;
    localparam int HW  = CW + RW + 1;
    localparam int BW  = ((QW > CENT_W) ? QW : CENT_W) + 9;
    localparam int DCW = (QW > 1) ? $clog2(QW) : 1;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SW-1:0]     sum_col_reg, sum_col_next;
    logic [SW-1:0]     sum_row_reg, sum_row_next;
    logic [HW-1:0]     hit_count_reg, hit_count_next;
    logic [CENT_W-1:0] avg_col_reg, avg_col_next;
    logic [CENT_W-1:0] avg_row_reg, avg_row_next;
    logic [SW-1:0]     rem_col_reg, rem_col_next;
    logic [SW-1:0]     rem_row_reg, rem_row_next;
    logic [SW-1:0]     dsh_reg, dsh_next;
    logic [QW-1:0]     quo_col_reg, quo_col_next;
    logic [QW-1:0]     quo_row_reg, quo_row_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [PIX_W-1:0]  pend_pix_reg, pend_pix_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pix_reg, out_pix_next;
    logic              out_done_reg, out_done_next;

    cbc_tag_t          tag;
    logic [CW-1:0]     col;
    logic [RW-1:0]     row;
    logic [PIX_W-1:0]  pix;
    logic              out_free;
    logic [SW-1:0]     sc_add, sr_add;
    logic [HW-1:0]     hc_add;
    logic              take_col, take_row;
    logic              band_row, band_col;
    logic [PIX_W-1:0]  mask_pix;

    assign tag = cbc_tag_t'(q_word[DW-1 -: TAG_W]);
    assign col = q_word[PIX_W+RW +: CW];
    assign row = q_word[PIX_W +: RW];
    assign pix = q_word[PIX_W-1:0];

    assign out_free = !out_valid_reg || !result_stall;
    assign q_pop    = (state_reg == ST_RUN) && q_valid && out_free;

    assign sc_add = sum_col_reg + (tag.hit ? SW'(col) : SW'(0));
    assign sr_add = sum_row_reg + (tag.hit ? SW'(row) : SW'(0));
    assign hc_add = hit_count_reg + HW'(tag.hit);

    assign mask_pix = tag.hit ? WHITE : '0;

    // band edges; the lower edge is clipped at zero by testing pos + HALF_BAND
    assign band_row = (BW'(row) <= BW'(avg_row_reg) + BW'(HALF_BAND)) &&
                      (BW'(row) + BW'(HALF_BAND) > BW'(avg_row_reg));
    assign band_col = (BW'(col) <= BW'(avg_col_reg) + BW'(HALF_BAND)) &&
                      (BW'(col) + BW'(HALF_BAND) > BW'(avg_col_reg));

    assign take_col = (rem_col_reg >= dsh_reg);
    assign take_row = (rem_row_reg >= dsh_reg);

    always_comb
    begin
        state_next     = state_reg;
        sum_col_next   = sum_col_reg;
        sum_row_next   = sum_row_reg;
        hit_count_next = hit_count_reg;
        avg_col_next   = avg_col_reg;
        avg_row_next   = avg_row_reg;
        rem_col_next   = rem_col_reg;
        rem_row_next   = rem_row_reg;
        dsh_next       = dsh_reg;
        quo_col_next   = quo_col_reg;
        quo_row_next   = quo_row_reg;
        div_cnt_next   = div_cnt_reg;
        pend_pix_next  = pend_pix_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_done_next  = out_done_reg;

        if (!result_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (q_pop)
                begin
                    if (tag.func == FUNC_MEASURE)
                    begin
                        if (tag.last)
                        begin
                            // frame end: start the divide, restart the sums
                            rem_col_next   = sc_add;
                            rem_row_next   = sr_add;
                            dsh_next       = SW'(hc_add) << (QW - 1);
                            quo_col_next   = '0;
                            quo_row_next   = '0;
                            div_cnt_next   = DCW'(QW - 1);
                            pend_pix_next  = mask_pix;
                            sum_col_next   = SW'(1);
                            sum_row_next   = SW'(1);
                            hit_count_next = HW'(1);
                            state_next     = ST_DIV;
                        end
                        else
                        begin
                            sum_col_next   = sc_add;
                            sum_row_next   = sr_add;
                            hit_count_next = hc_add;
                            out_valid_next = 1'b1;
                            out_pix_next   = mask_pix;
                            out_done_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_pix_next   = (band_row || band_col) ? WHITE : pix;
                        out_done_next  = tag.last;
                    end
                end
            end

            ST_DIV:
            begin
                // restoring divide, quotient fits QW bits since sum < count << QW
                if (take_col)
                    rem_col_next = rem_col_reg - dsh_reg;
                if (take_row)
                    rem_row_next = rem_row_reg - dsh_reg;
                quo_col_next = (quo_col_reg << 1) | QW'(take_col);
                quo_row_next = (quo_row_reg << 1) | QW'(take_row);
                dsh_next     = dsh_reg >> 1;
                if (div_cnt_reg == '0)
                begin
                    avg_col_next = CENT_W'(quo_col_next);
                    avg_row_next = CENT_W'(quo_row_next);
                    state_next   = ST_EMIT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DCW'(1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pend_pix_reg;
                    out_done_next  = 1'b1;
                    state_next     = ST_RUN;
                end
            end

            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            sum_col_reg   <= SW'(1);
            sum_row_reg   <= SW'(1);
            hit_count_reg <= HW'(1);
            avg_col_reg   <= '0;
            avg_row_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_col_reg   <= sum_col_next;
            sum_row_reg   <= sum_row_next;
            hit_count_reg <= hit_count_next;
            avg_col_reg   <= avg_col_next;
            avg_row_reg   <= avg_row_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_col_reg  <= rem_col_next;
        rem_row_reg  <= rem_row_next;
        dsh_reg      <= dsh_next;
        quo_col_reg  <= quo_col_next;
        quo_row_reg  <= quo_row_next;
        pend_pix_reg <= pend_pix_next;
        out_pix_reg  <= out_pix_next;
        out_done_reg <= out_done_next;
    end

    // centroid only moves while the output register is empty
    assign result_valid = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign pass_done    = out_done_reg;
    assign centroid_col = avg_col_reg;
    assign centroid_row = avg_row_reg;

    a_div_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_EMIT) |-> !out_valid_reg)
        else $error("output word pending while centroid is updating");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg != '0) |=> state_reg == ST_DIV)
        else $error("divide left early");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_count_reg != '0)
        else $error("hit count reached zero");

endmodule

/* rtl/color_blob_centroid_crosshair.sv */
// color_blob_centroid_crosshair: top level; configuration registers, front, queue, back.
// Depends on cbc_pkg, cbc_front, cbc_fifo, cbc_back.
//
// Takes one pixel word per cycle in raster order while item_stall is low. In the measure
// pass (func 0) each word yields a mask word (white or zero) and the hit coordinates are
// summed; on the last pixel of the frame the centroid is divided out by a shift-subtract
// divider that produces one quotient bit per cycle, and that word comes out with the new
// centroid. In the draw pass (func 1) pixels within HALF_BAND of the centroid row or
// column turn white. Sustained rate is one word per cycle while result_stall is low,
// except at the end of a measure pass, where the back end stops popping while the divider
// runs and the last word is emitted; the four-word queue absorbs part of that before
// item_stall rises. Each word is registered in the queue and then in the output register.
// Configuration writes (cfg_ready is always high) are meant for idle periods.
module color_blob_centroid_crosshair
    import cbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int HALF_BAND  = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 func,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 pass_done,
    output logic [CENT_W-1:0]    centroid_col,
    output logic [CENT_W-1:0]    centroid_row,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = TAG_W + CW + RW + PIX_W;

    cbc_color_win_t     win_reg;
    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;

    logic          q_full;
    logic          q_push;
    logic [DW-1:0] q_push_word;
    logic          q_pop;
    logic [DW-1:0] q_pop_word;
    logic          q_not_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.red.lo   <= RST_RED_LOW;
            win_reg.red.hi   <= RST_RED_HIGH;
            win_reg.green.lo <= RST_GREEN_LOW;
            win_reg.green.hi <= RST_GREEN_HIGH;
            win_reg.blue.lo  <= RST_BLUE_LOW;
            win_reg.blue.hi  <= RST_BLUE_HIGH;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RED_LOW:      win_reg.red.lo   <= COLOR_W'(cfg_data);
                CFG_RED_HIGH:     win_reg.red.hi   <= COLOR_W'(cfg_data);
                CFG_GREEN_LOW:    win_reg.green.lo <= COLOR_W'(cfg_data);
                CFG_GREEN_HIGH:   win_reg.green.hi <= COLOR_W'(cfg_data);
                CFG_BLUE_LOW:     win_reg.blue.lo  <= COLOR_W'(cfg_data);
                CFG_BLUE_HIGH:    win_reg.blue.hi  <= COLOR_W'(cfg_data);
                CFG_FRAME_WIDTH:  frame_width_reg  <= FRAME_W'(cfg_data);
                CFG_FRAME_HEIGHT: frame_height_reg <= FRAME_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    cbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .DW         (DW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .pixel_in     (pixel_in),
        .win          (win_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_word       (q_push_word)
    );

    cbc_fifo #(
        .DW    (DW),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .pop_word  (q_pop_word),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    cbc_back #(
        .HALF_BAND (HALF_BAND),
        .CW        (CW),
        .RW        (RW),
        .DW        (DW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_word       (q_pop_word),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .pass_done    (pass_done),
        .centroid_col (centroid_col),
        .centroid_row (centroid_row)
    );

endmodule
